// File: hw/rtl/quad_lane_i2c_register_reader_unit_assert.svh
// Assertion macros used by the top level of the register reader.
`ifndef QUAD_LANE_I2C_REGISTER_READER_UNIT_ASSERT_SVH
`define QUAD_LANE_I2C_REGISTER_READER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define QLRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QLRD_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define QLRD_ASSERT(lbl, prop, msg)
`define QLRD_NEVER(lbl, expr, msg)
`endif
`endif

// File: hw/rtl/qlrd_pkg.sv
// Types and constants of the four-lane I2C register reader.
package qlrd_pkg;

    localparam int LANES     = 4;
    localparam int IN_LINES  = 4;
    localparam int OUT_LANES = 4;
    localparam int VALUE_W   = 16;
    localparam int ADDR_W    = 7;
    localparam int BYTE_W    = 8;
    localparam int TICK_W    = 8;
    localparam int BIT_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 72;

    localparam logic [BIT_W-1:0]  ACK_SLOT       = 4'd8;
    localparam logic [ADDR_W-1:0] ADDR_RESET     = 7'd72;
    localparam logic [BYTE_W-1:0] POINTER_RESET  = 8'd1;
    localparam logic [TICK_W-1:0] HIGH_RESET     = 8'd32;
    localparam logic [TICK_W-1:0] LOW_RESET      = 8'd8;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_START_A = 5'd1,
        PH_START_B = 5'd2,
        PH_AW_LO   = 5'd3,
        PH_AW_HI   = 5'd4,
        PH_PT_LO   = 5'd5,
        PH_PT_HI   = 5'd6,
        PH_RS_A    = 5'd7,
        PH_RS_B    = 5'd8,
        PH_RS_C    = 5'd9,
        PH_AR_LO   = 5'd10,
        PH_AR_HI   = 5'd11,
        PH_R1_LO   = 5'd12,
        PH_R1_HI   = 5'd13,
        PH_R2_LO   = 5'd14,
        PH_R2_HI   = 5'd15,
        PH_STOP_A  = 5'd16,
        PH_STOP_B  = 5'd17,
        PH_STOP_C  = 5'd18
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE_ADDR       = 2'd0,
        CFG_REGISTER_POINTER = 2'd1,
        CFG_CLOCK_HIGH_TICKS = 2'd2,
        CFG_CLOCK_LOW_TICKS  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [ADDR_W-1:0] slave_addr;
        logic [BYTE_W-1:0] register_pointer;
        logic [TICK_W-1:0] clock_high_ticks;
        logic [TICK_W-1:0] clock_low_ticks;
    } cfg_t;

    typedef struct packed {
        logic                               clock_level;
        logic                               data_level;
        logic                               data_released;
        logic                               busy;
        logic                               done;
        logic [OUT_LANES-1:0][VALUE_W-1:0]  lane_value;
        logic                               toggle;
    } res_t;

endpackage

// File: hw/rtl/qlrd_cfg.sv
// Configuration register file of the register reader.
module qlrd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [qlrd_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [qlrd_pkg::BYTE_W-1:0]    wr_data,
    output qlrd_pkg::cfg_t                cfg
);
    import qlrd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_SLAVE_ADDR:       cfg_next.slave_addr       = wr_data[ADDR_W-1:0];
                CFG_REGISTER_POINTER: cfg_next.register_pointer = wr_data;
                CFG_CLOCK_HIGH_TICKS: cfg_next.clock_high_ticks = wr_data;
                CFG_CLOCK_LOW_TICKS:  cfg_next.clock_low_ticks  = wr_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_addr       <= ADDR_RESET;
            cfg_reg.register_pointer <= POINTER_RESET;
            cfg_reg.clock_high_ticks <= HIGH_RESET;
            cfg_reg.clock_low_ticks  <= LOW_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/qlrd_seq.sv
// Bus sequencer: one tick of the I2C waveform per step, with lane capture.
module qlrd_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          start_request,
    input  logic [qlrd_pkg::IN_LINES-1:0] data_line_in,
    input  qlrd_pkg::cfg_t                cfg,
    output qlrd_pkg::res_t                res
);
    import qlrd_pkg::*;

    phase_t                          phase_reg,       phase_next;
    logic [BIT_W-1:0]                bit_index_reg,   bit_index_next;
    logic [TICK_W-1:0]               tick_count_reg,  tick_count_next;
    logic [BYTE_W-1:0]               send_shift_reg,  send_shift_next;
    logic [LANES-1:0][VALUE_W-1:0]   capture_reg,     capture_next;
    logic [LANES-1:0][VALUE_W-1:0]   result_reg,      result_next;
    logic                            toggle_reg,      toggle_next;

    // Values after idle entry is resolved for this tick.
    phase_t                          ph;
    logic [BIT_W-1:0]                bi;
    logic [TICK_W-1:0]               tc;
    logic [LANES-1:0][VALUE_W-1:0]   cap;

    logic                            scl;
    logic                            sda;
    logic                            rel;
    logic                            sample;
    logic                            done;
    logic                            low_seg;
    logic [TICK_W-1:0]               dur;
    logic [TICK_W:0]                 tc_inc;
    logic [LANES+IN_LINES-1:0]       lines_ext;

    assign lines_ext = {{LANES{1'b0}}, data_line_in};

    always_comb
    begin
        ph  = phase_reg;
        bi  = bit_index_reg;
        tc  = tick_count_reg;
        cap = capture_reg;
        if (phase_reg > PH_STOP_C)
        begin
            ph = PH_IDLE;
        end
        if (ph == PH_IDLE && start_request)
        begin
            ph  = PH_START_A;
            tc  = '0;
            bi  = '0;
            cap = '0;
        end
    end

    // Bus levels of the current segment.
    always_comb
    begin
        scl     = 1'b1;
        sda     = 1'b1;
        rel     = 1'b0;
        sample  = 1'b0;
        low_seg = 1'b0;
        case (ph)
            PH_IDLE: ;
            PH_START_A, PH_RS_B, PH_STOP_C: sda = 1'b1;
            PH_START_B, PH_RS_C, PH_STOP_B: sda = 1'b0;
            PH_RS_A:
            begin
                low_seg = 1'b1;
                sda     = 1'b1;
            end
            PH_STOP_A:
            begin
                low_seg = 1'b1;
                sda     = 1'b0;
            end
            PH_AW_LO, PH_AW_HI, PH_PT_LO, PH_PT_HI, PH_AR_LO, PH_AR_HI:
            begin
                low_seg = (ph == PH_AW_LO) || (ph == PH_PT_LO) || (ph == PH_AR_LO);
                if (bi < ACK_SLOT)
                begin
                    sda = send_shift_reg[BYTE_W-1];
                end
                else
                begin
                    sda = 1'b0;
                    rel = 1'b1;
                end
            end
            PH_R1_LO, PH_R1_HI, PH_R2_LO, PH_R2_HI:
            begin
                low_seg = (ph == PH_R1_LO) || (ph == PH_R2_LO);
                if (bi < ACK_SLOT)
                begin
                    sda    = 1'b0;
                    rel    = 1'b1;
                    sample = !low_seg && (tc == '0);
                end
                else
                begin
                    // The first byte is acknowledged, the second is not.
                    sda = (ph == PH_R2_LO) || (ph == PH_R2_HI);
                end
            end
            default: ;
        endcase
        scl = !low_seg;
    end

    always_comb
    begin
        phase_next      = ph;
        bit_index_next  = bi;
        tick_count_next = tc;
        send_shift_next = send_shift_reg;
        capture_next    = cap;
        result_next     = result_reg;
        toggle_next     = toggle_reg;
        done            = 1'b0;

        for (int k = 0; k < LANES; k++)
        begin
            if (sample)
            begin
                capture_next[k] = {cap[k][VALUE_W-2:0], lines_ext[k]};
            end
        end

        dur = low_seg ? cfg.clock_low_ticks : cfg.clock_high_ticks;
        if (dur == '0)
        begin
            dur = TICK_W'(1);
        end
        tc_inc = {1'b0, tc} + (TICK_W+1)'(1);

        if (ph != PH_IDLE)
        begin
            if (tc_inc >= {1'b0, dur})
            begin
                tick_count_next = '0;
                case (ph)
                    PH_START_A: phase_next = PH_START_B;
                    PH_START_B:
                    begin
                        phase_next      = PH_AW_LO;
                        bit_index_next  = '0;
                        send_shift_next = {cfg.slave_addr, 1'b0};
                    end
                    PH_RS_A: phase_next = PH_RS_B;
                    PH_RS_B: phase_next = PH_RS_C;
                    PH_RS_C:
                    begin
                        phase_next      = PH_AR_LO;
                        bit_index_next  = '0;
                        send_shift_next = {cfg.slave_addr, 1'b1};
                    end
                    PH_STOP_A: phase_next = PH_STOP_B;
                    PH_STOP_B: phase_next = PH_STOP_C;
                    PH_STOP_C:
                    begin
                        phase_next  = PH_IDLE;
                        result_next = capture_next;
                        toggle_next = !toggle_reg;
                        done        = 1'b1;
                    end
                    PH_AW_LO: phase_next = PH_AW_HI;
                    PH_PT_LO: phase_next = PH_PT_HI;
                    PH_AR_LO: phase_next = PH_AR_HI;
                    PH_R1_LO: phase_next = PH_R1_HI;
                    PH_R2_LO: phase_next = PH_R2_HI;
                    PH_AW_HI, PH_PT_HI, PH_AR_HI, PH_R1_HI, PH_R2_HI:
                    begin
                        if (bi < ACK_SLOT)
                        begin
                            bit_index_next  = bi + BIT_W'(1);
                            send_shift_next = {send_shift_reg[BYTE_W-2:0], 1'b0};
                            case (ph)
                                PH_AW_HI: phase_next = PH_AW_LO;
                                PH_PT_HI: phase_next = PH_PT_LO;
                                PH_AR_HI: phase_next = PH_AR_LO;
                                PH_R1_HI: phase_next = PH_R1_LO;
                                default:  phase_next = PH_R2_LO;
                            endcase
                        end
                        else
                        begin
                            bit_index_next = '0;
                            case (ph)
                                PH_AW_HI:
                                begin
                                    phase_next      = PH_PT_LO;
                                    send_shift_next = cfg.register_pointer;
                                end
                                PH_PT_HI: phase_next = PH_RS_A;
                                PH_AR_HI: phase_next = PH_R1_LO;
                                PH_R1_HI: phase_next = PH_R2_LO;
                                default:  phase_next = PH_STOP_A;
                            endcase
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
            else
            begin
                tick_count_next = tc_inc[TICK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= '0;
            tick_count_reg <= '0;
            send_shift_reg <= '0;
            capture_reg    <= '0;
            result_reg     <= '0;
            toggle_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            tick_count_reg <= tick_count_next;
            send_shift_reg <= send_shift_next;
            capture_reg    <= capture_next;
            result_reg     <= result_next;
            toggle_reg     <= toggle_next;
        end
    end

    always_comb
    begin
        res.clock_level   = scl;
        res.data_level    = sda;
        res.data_released = rel;
        res.busy          = (ph != PH_IDLE);
        res.done          = done;
        res.toggle        = toggle_next;
        for (int k = 0; k < OUT_LANES; k++)
        begin
            res.lane_value[k] = '0;
            if (k < LANES)
            begin
                res.lane_value[k] = result_next[k];
            end
        end
    end

endmodule

// File: hw/rtl/quad_lane_i2c_register_reader_unit.sv
// Top level of the four-lane I2C register reader: stream stages around the sequencer.
//
//  Channel  Handshake             Payload
//  s_*      s_tvalid / s_tready   s_tdata: one bus tick in
//  m_*      m_tvalid / m_tready   m_tdata: bus levels and readings for that tick
//  cfg_*    cfg_valid / cfg_ready cfg_index, cfg_data: register write
//
// One tick is taken per clock cycle unless the result stalls; the sequencer step
// between the input register and the result register sets that rate.
// Reset puts the bus idle (SCL and SDA high), clears the readings and loads the
// register defaults. A stalled result holds the result register and then the input
// register; the configuration channel is always ready.
`include "quad_lane_i2c_register_reader_unit_assert.svh"

module quad_lane_i2c_register_reader_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [0] start_request, [4:1] data_line_in, [7:5] zero
    input  logic [qlrd_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] clock_level, [1] data_level, [2] data_released, [3] busy_res,
    // [4] reading_done, [20:5] lane0_value, [36:21] lane1_value,
    // [52:37] lane2_value, [68:53] lane3_value, [69] reading_toggle, [71:70] zero
    output logic [qlrd_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [qlrd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qlrd_pkg::BYTE_W-1:0]      cfg_data
);
    import qlrd_pkg::*;

    logic                 in_valid_reg,  in_valid_next;
    logic                 in_start_reg;
    logic [IN_LINES-1:0]  in_lines_reg;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_res_reg;

    logic                 s_accept;
    logic                 step;
    cfg_t                 cfg;
    res_t                 seq_res;

    assign cfg_ready = 1'b1;
    assign step      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step;
    assign s_accept  = s_tvalid && s_tready;

    qlrd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    qlrd_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .start_request (in_start_reg),
        .data_line_in  (in_lines_reg),
        .cfg           (cfg),
        .res           (seq_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_start_reg <= s_tdata[0];
            in_lines_reg <= s_tdata[IN_LINES:1];
        end
        if (step)
        begin
            out_res_reg <= seq_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_res_reg.toggle,
                       out_res_reg.lane_value[3],
                       out_res_reg.lane_value[2],
                       out_res_reg.lane_value[1],
                       out_res_reg.lane_value[0],
                       out_res_reg.done,
                       out_res_reg.busy,
                       out_res_reg.data_released,
                       out_res_reg.data_level,
                       out_res_reg.clock_level};

    // A transaction ends on a tick that still counts as busy.
    `QLRD_ASSERT(a_done_busy, (m_tvalid && out_res_reg.done) |-> out_res_reg.busy, "done without busy")
    // A released data line is never reported as driven high.
    `QLRD_NEVER(a_rel_low, m_tvalid && out_res_reg.data_released && out_res_reg.data_level, "released SDA driven high")
    // The input side only stalls while an item waits in the input register.
    `QLRD_ASSERT(a_stall_full, !s_tready |-> in_valid_reg, "input stalled while empty")

endmodule

// File: tb/quad_lane_i2c_register_reader_unit_tb.sv
// Self-checking testbench for the four-lane I2C register reader: random ticks against a tick predictor.
module quad_lane_i2c_register_reader_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qlrd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic       start;
        logic [3:0] lines;
    } tick_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0] cfg_data = '0;

    quad_lane_i2c_register_reader_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    tick_t ticks_to_send[$];
    res_t  pending_levels[$];
    int    idle_mode = 0;
    int    fails = 0;
    int unsigned cycle_count = 0;

    // Predictor state and its copy of the registers.
    logic [ADDR_W-1:0]  dev_addr = ADDR_RESET;
    logic [BYTE_W-1:0]  reg_ptr = POINTER_RESET;
    logic [TICK_W-1:0]  hi_ticks = HIGH_RESET;
    logic [TICK_W-1:0]  lo_ticks = LOW_RESET;
    phase_t             bus_phase = PH_IDLE;
    logic [BIT_W-1:0]   bit_idx = '0;
    logic [TICK_W-1:0]  tick_cnt = '0;
    logic [BYTE_W-1:0]  shift_reg = '0;
    logic [VALUE_W-1:0] lane_shift [LANES] = '{default: '0};
    logic [VALUE_W-1:0] lane_latch [LANES] = '{default: '0};
    logic               reading_flip = 1'b0;

    task automatic step_bus(input logic start, input logic [3:0] lines, output res_t r);
        logic [TICK_W-1:0] span;
        logic seg_low;
        logic ends;
        r = '0;
        r.clock_level = 1'b1;
        r.data_level = 1'b1;
        ends = 1'b0;
        if (bus_phase == PH_IDLE && start)
        begin
            bus_phase = PH_START_A;
            tick_cnt = '0;
            bit_idx = '0;
            for (int k = 0; k < LANES; k++)
                lane_shift[k] = '0;
        end
        if (bus_phase != PH_IDLE)
        begin
            r.busy = 1'b1;
            case (bus_phase)
                PH_AW_LO, PH_PT_LO, PH_AR_LO, PH_R1_LO, PH_R2_LO, PH_RS_A, PH_STOP_A:
                    seg_low = 1'b1;
                default:
                    seg_low = 1'b0;
            endcase
            r.clock_level = !seg_low;
            case (bus_phase)
                PH_START_A, PH_RS_A, PH_RS_B, PH_STOP_C:
                    r.data_level = 1'b1;
                PH_START_B, PH_RS_C, PH_STOP_A, PH_STOP_B:
                    r.data_level = 1'b0;
                PH_AW_LO, PH_AW_HI, PH_PT_LO, PH_PT_HI, PH_AR_LO, PH_AR_HI:
                    if (bit_idx < ACK_SLOT)
                        r.data_level = shift_reg[BYTE_W-1];
                    else
                    begin
                        r.data_level = 1'b0;
                        r.data_released = 1'b1;
                    end
                default:
                    if (bit_idx < ACK_SLOT)
                    begin
                        r.data_level = 1'b0;
                        r.data_released = 1'b1;
                        // Read bits are sampled on the first tick of SCL high.
                        if ((bus_phase == PH_R1_HI || bus_phase == PH_R2_HI) && tick_cnt == '0)
                            for (int k = 0; k < LANES; k++)
                                lane_shift[k] = {lane_shift[k][VALUE_W-2:0], lines[k]};
                    end
                    else
                        // ACK after the first byte, NACK after the second.
                        r.data_level = (bus_phase == PH_R2_LO || bus_phase == PH_R2_HI);
            endcase

            span = seg_low ? lo_ticks : hi_ticks;
            if (span == '0)
                span = 8'd1;
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt >= span)
            begin
                tick_cnt = '0;
                case (bus_phase)
                    PH_START_A: bus_phase = PH_START_B;
                    PH_START_B:
                    begin
                        bus_phase = PH_AW_LO;
                        bit_idx = '0;
                        shift_reg = {dev_addr, 1'b0};
                    end
                    PH_RS_A: bus_phase = PH_RS_B;
                    PH_RS_B: bus_phase = PH_RS_C;
                    PH_RS_C:
                    begin
                        bus_phase = PH_AR_LO;
                        bit_idx = '0;
                        shift_reg = {dev_addr, 1'b1};
                    end
                    PH_STOP_A: bus_phase = PH_STOP_B;
                    PH_STOP_B: bus_phase = PH_STOP_C;
                    PH_STOP_C:
                    begin
                        bus_phase = PH_IDLE;
                        ends = 1'b1;
                    end
                    PH_AW_LO, PH_PT_LO, PH_AR_LO, PH_R1_LO, PH_R2_LO:
                        bus_phase = phase_t'(bus_phase + 5'd1);
                    PH_AW_HI, PH_PT_HI, PH_AR_HI, PH_R1_HI, PH_R2_HI:
                        if (bit_idx < ACK_SLOT)
                        begin
                            bit_idx = bit_idx + 4'd1;
                            shift_reg = shift_reg << 1;
                            bus_phase = phase_t'(bus_phase - 5'd1);
                        end
                        else
                        begin
                            bit_idx = '0;
                            case (bus_phase)
                                PH_AW_HI:
                                begin
                                    bus_phase = PH_PT_LO;
                                    shift_reg = reg_ptr;
                                end
                                PH_PT_HI: bus_phase = PH_RS_A;
                                PH_AR_HI: bus_phase = PH_R1_LO;
                                PH_R1_HI: bus_phase = PH_R2_LO;
                                default:  bus_phase = PH_STOP_A;
                            endcase
                        end
                    default: bus_phase = PH_IDLE;
                endcase
            end
            if (ends)
            begin
                for (int k = 0; k < LANES; k++)
                    lane_latch[k] = lane_shift[k];
                reading_flip = !reading_flip;
                r.done = 1'b1;
            end
        end
        for (int k = 0; k < LANES; k++)
            r.lane_value[k] = lane_latch[k];
        r.toggle = reading_flip;
    endtask

    task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    // Sender side: one tick per accepted item, predicted at the accepting edge.
    always @(posedge clk)
    begin
        res_t  levels;
        tick_t t;
        logic  gap;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                step_bus(s_tdata[0], s_tdata[4:1], levels);
                pending_levels.push_back(levels);
            end
            if (!s_tvalid || s_tready)
            begin
                gap = ($urandom_range(0, 99) < (idle_mode == 0 ? 28 : idle_mode == 1 ? 49 : 0));
                if (ticks_to_send.size() != 0 && !gap)
                begin
                    t = ticks_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {3'b000, t.lines, t.start};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver side: stalls at random and checks every accepted result.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(0, 99) >=
                         (idle_mode == 0 ? 49 : idle_mode == 1 ? 28 : 0));
            if (m_tvalid && m_tready)
            begin
                if (pending_levels.size() == 0)
                begin
                    $error("result item arrived with no tick waiting for it");
                    fails++;
                end
                else
                begin
                    want = pending_levels.pop_front();
                    cmp_field("clock_level", want.clock_level, m_tdata[0]);
                    cmp_field("data_level", want.data_level, m_tdata[1]);
                    cmp_field("data_released", want.data_released, m_tdata[2]);
                    cmp_field("busy_res", want.busy, m_tdata[3]);
                    cmp_field("reading_done", want.done, m_tdata[4]);
                    cmp_field("lane0_value", want.lane_value[0], m_tdata[20:5]);
                    cmp_field("lane1_value", want.lane_value[1], m_tdata[36:21]);
                    cmp_field("lane2_value", want.lane_value[2], m_tdata[52:37]);
                    cmp_field("lane3_value", want.lane_value[3], m_tdata[68:53]);
                    cmp_field("reading_toggle", want.toggle, m_tdata[69]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [BYTE_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SLAVE_ADDR:       dev_addr = val[ADDR_W-1:0];
            CFG_REGISTER_POINTER: reg_ptr = val;
            CFG_CLOCK_HIGH_TICKS: hi_ticks = val;
            CFG_CLOCK_LOW_TICKS:  lo_ticks = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (ticks_to_send.size() != 0 || s_tvalid || pending_levels.size() != 0)
            @(negedge clk);
    endtask

    task automatic push_tick(input logic start, input logic [3:0] lines);
        tick_t t;
        t.start = start;
        t.lines = lines;
        ticks_to_send.push_back(t);
    endtask

    initial
    begin
        int batch;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Idle bus at the reset registers, then a start and starts while busy.
        push_tick(1'b0, 4'h0);
        push_tick(1'b0, 4'hF);
        push_tick(1'b0, 4'h5);
        push_tick(1'b1, 4'hF);
        push_tick(1'b1, 4'h0);
        push_tick(1'b1, 4'hA);

        // The sender holds off here until every result is back.
        wait_drained();
        // Durations change mid-transaction; a zero tick count acts as one tick.
        write_reg(CFG_CLOCK_HIGH_TICKS, 8'd0);
        write_reg(CFG_CLOCK_LOW_TICKS, 8'd1);
        write_reg(CFG_SLAVE_ADDR, 8'd127);
        write_reg(CFG_REGISTER_POINTER, 8'd255);
        @(negedge clk);
        for (int i = 0; i < 19; i++)
            push_tick(i[0], 4'(i * 5));

        for (int s = 0; s < 9; s++)
        begin
            wait_drained();
            if (s == 3)
                idle_mode = 1;
            if (s == 6)
                idle_mode = 2;
            case (s)
                0:
                begin
                    write_reg(CFG_SLAVE_ADDR, 8'd0);
                    write_reg(CFG_REGISTER_POINTER, 8'd0);
                    write_reg(CFG_CLOCK_HIGH_TICKS, 8'd255);
                    write_reg(CFG_CLOCK_LOW_TICKS, 8'd255);
                    batch = 150;
                end
                1:
                begin
                    write_reg(CFG_SLAVE_ADDR, 8'($urandom_range(0, 127)));
                    write_reg(CFG_REGISTER_POINTER, 8'($urandom_range(0, 255)));
                    write_reg(CFG_CLOCK_HIGH_TICKS, 8'd1);
                    write_reg(CFG_CLOCK_LOW_TICKS, 8'd1);
                    batch = 120;
                end
                default:
                begin
                    write_reg(CFG_SLAVE_ADDR, 8'($urandom_range(0, 127)));
                    write_reg(CFG_REGISTER_POINTER, 8'($urandom_range(0, 255)));
                    write_reg(CFG_CLOCK_HIGH_TICKS, 8'($urandom_range(1, 3)));
                    write_reg(CFG_CLOCK_LOW_TICKS, 8'($urandom_range(1, 3)));
                    batch = 75;
                end
            endcase
            @(negedge clk);
            for (int i = 0; i < batch; i++)
                push_tick($urandom_range(0, 3) == 0, 4'($urandom_range(0, 15)));
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: quad_lane_i2c_register_reader_unit.f
+incdir+hw/rtl
hw/rtl/qlrd_pkg.sv
hw/rtl/qlrd_cfg.sv
hw/rtl/qlrd_seq.sv
hw/rtl/quad_lane_i2c_register_reader_unit.sv
tb/quad_lane_i2c_register_reader_unit_tb.sv
